@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

@@ rtl/core/brs_pkg.sv @@
// ----------------------------------------------------------------------------
// brs_pkg
// Types and constants shared by the run sorter cells, control and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

	localparam int RUN_SIZE = 32;
	localparam int KEY_W    = 31;
	localparam int PAY_W    = 16;
	localparam int CNT_W    = $clog2(RUN_SIZE + 1);

	typedef struct packed {
		logic [KEY_W-1:0] sort_key;
		logic [PAY_W-1:0] payload;
		logic             end_of_input;
	} brs_in_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic             run_last;
	} brs_out_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} brs_entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} brs_op_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} brs_state_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		brs_op_t          op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} brs_cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/brs_cell.sv @@
// ----------------------------------------------------------------------------
// brs_cell
// One slot of the systolic insertion chain: holds one record, compares it
// against the broadcast key and trades contents with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brs_cell
	import brs_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire brs_cell_ctrl_t ctrl,
	input  wire brs_entry_t     prev_entry,
	input  wire logic           prev_ins,
	input  wire brs_entry_t     next_entry,
	output brs_entry_t          entry,
	output logic                ins
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;

	logic             valid_d;
	logic [KEY_W-1:0] key_d;
	logic [PAY_W-1:0] payload_d;

	assign entry = '{valid: valid_q, key: key_q, payload: payload_q};

	// Strictly greater keeps equal keys in arrival order.
	assign ins = !valid_q || (key_q > ctrl.key);

	always_comb begin
		valid_d   = valid_q;
		key_d     = key_q;
		payload_d = payload_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (prev_ins) begin
					valid_d   = prev_entry.valid;
					key_d     = prev_entry.key;
					payload_d = prev_entry.payload;
				end else if (ins) begin
					valid_d   = 1'b1;
					key_d     = ctrl.key;
					payload_d = ctrl.payload;
				end
			end
			OP_SHIFT: begin
				valid_d   = next_entry.valid;
				key_d     = next_entry.key;
				payload_d = next_entry.payload;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= key_d;
		payload_q <= payload_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/brs_ctrl.sv @@
// ----------------------------------------------------------------------------
// brs_ctrl
// Run control: counts buffered records, closes a run, and drains the chain
// head into the result register one record per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brs_ctrl
	import brs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire brs_in_t    rec,
	input  wire brs_entry_t head_entry,
	input  wire logic       second_valid,
	output brs_cell_ctrl_t  cell_ctrl,
	output brs_out_t        result,
	output logic            result_valid
);

	brs_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	brs_out_t         result_q, result_d;
	logic             strobe_q, strobe_d;
	logic             accept;
	logic             close_run;

	assign busy         = (state_q == ST_DRAIN);
	assign accept       = start && (state_q == ST_FILL);
	assign close_run    = rec.end_of_input || (count_q == CNT_W'(RUN_SIZE - 1));
	assign result       = result_q;
	assign result_valid = strobe_q;

	always_comb begin
		state_d           = state_q;
		count_d           = count_q;
		result_d          = result_q;
		strobe_d          = 1'b0;
		cell_ctrl.op      = OP_HOLD;
		cell_ctrl.key     = rec.sort_key;
		cell_ctrl.payload = rec.payload;
		case (state_q)
			ST_FILL: begin
				if (accept) begin
					cell_ctrl.op = OP_INSERT;
					if (close_run) begin
						count_d = '0;
						state_d = ST_DRAIN;
					end else begin
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			ST_DRAIN: begin
				cell_ctrl.op         = OP_SHIFT;
				strobe_d             = 1'b1;
				result_d.out_key     = head_entry.key;
				result_d.out_payload = head_entry.payload;
				result_d.run_last    = !second_valid;
				if (!second_valid) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/bounded_run_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_run_sorter_unit
// Run generation for an external sort on a systolic insertion chain.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low; rec holds
// the sort key, the payload handle and the end_of_input flag. Each taken
// record is inserted into a chain of RUN_SIZE cells in the same cycle, so
// records are accepted one per cycle while a run is being collected.
// A run closes on the record that fills the chain or that carries
// end_of_input. busy then rises and stays high while the run drains.
// The chain shifts its head out once per cycle; each result appears on result
// for one cycle with result_valid high, the first once the closing request has
// set the drain state and the chain head has passed the result register, in
// ascending key order with equal keys in arrival order, and run_last marks
// the final record; the drain is paced by the single-slot shift of the chain.
// The receiver cannot stall; results must be taken as they appear.
// Reset empties every cell and returns to collecting; no results follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_run_sorter_unit
	import brs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire brs_in_t rec,
	output brs_out_t     result,
	output logic         result_valid
);

	brs_cell_ctrl_t cell_ctrl;
	brs_entry_t     cell_entry [RUN_SIZE];
	logic           cell_ins   [RUN_SIZE];

	brs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rec          (rec),
		.head_entry   (cell_entry[0]),
		.second_valid (cell_entry[1].valid),
		.cell_ctrl    (cell_ctrl),
		.result       (result),
		.result_valid (result_valid)
	);

	for (genvar i = 0; i < RUN_SIZE; i++) begin : g_cell
		brs_entry_t prev_e;
		brs_entry_t next_e;
		logic       prev_i;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_i = 1'b0;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_i = cell_ins[i-1];
		end

		if (i == RUN_SIZE - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		brs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.prev_entry (prev_e),
			.prev_ins   (prev_i),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.ins        (cell_ins[i])
		);
	end

endmodule

`default_nettype wire

@@ rtl/core/brs_checker.sv @@
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks on the run sorter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module brs_checker
	import brs_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire brs_in_t  rec,
	input wire brs_out_t result,
	input wire logic     result_valid
);

	logic             prev_open_q;
	logic [KEY_W-1:0] prev_key_q;

	// Remembers whether the previous cycle carried a result that left its run open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_open_q <= 1'b0;
			prev_key_q  <= '0;
		end else begin
			prev_open_q <= result_valid && !result.run_last;
			prev_key_q  <= result.out_key;
		end
	end

	// Results only follow a cycle in which the block was draining.
	`ASSERT_SAME(a_result_after_busy, clk, arst_n, result_valid, $past(busy))

	// A request that ends the input always closes a run.
	`ASSERT_NEXT(a_last_closes_run, clk, arst_n, start && !busy && rec.end_of_input, busy)

	// A run leaves without gaps until its final record.
	`ASSERT_NEXT(a_run_contiguous, clk, arst_n, result_valid && !result.run_last, result_valid)

	// Keys do not decrease within one run.
	`ASSERT_SAME(a_keys_ascend, clk, arst_n, result_valid && prev_open_q, result.out_key >= prev_key_q)

endmodule

bind bounded_run_sorter_unit brs_checker u_brs_checker (.*);

`default_nettype wire
